FILE: design/u8d_pkg.sv
package u8d_pkg;

    // character limit per text and the counter that tracks it
    localparam int MAX_CHARS = 1024;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int IDX_W     = 10;
    localparam int CP_W      = 21;

    localparam logic [CNT_W-1:0] MAX_CHARS_C = CNT_W'(MAX_CHARS);

    // byte class masks and patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [IDX_W-1:0] char_index;
        logic             char_valid;
        logic             end_of_text;
    } out_item_t;

    // decoder state carried from one byte to the next
    typedef struct packed {
        logic [CP_W-1:0]  partial_value;
        logic [1:0]       bytes_pending;
        logic [CNT_W-1:0] chars_emitted;
    } dec_state_t;

endpackage

FILE: design/u8d_decode.sv
module u8d_decode (
    input  u8d_pkg::dec_state_t state,
    input  u8d_pkg::in_item_t   item,
    output u8d_pkg::dec_state_t state_next,
    output u8d_pkg::out_item_t  result,
    output logic                has_result
);

    logic [7:0]                       b;
    logic                             is_cont;
    logic                             below_limit;
    logic                             done;
    logic [u8d_pkg::CP_W-1:0]         partial;
    logic [1:0]                       pending;
    logic [u8d_pkg::CNT_W+u8d_pkg::IDX_W-1:0] cnt_ext;

    assign b       = item.data_byte;
    assign is_cont = (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_PAT;
    assign below_limit = state.chars_emitted < u8d_pkg::MAX_CHARS_C;
    assign cnt_ext = {{u8d_pkg::IDX_W{1'b0}}, state.chars_emitted};

    // byte classification and sequence assembly
    always_comb
    begin
        done    = 1'b0;
        partial = state.partial_value;
        pending = state.bytes_pending;
        if (below_limit)
        begin
            if (state.bytes_pending != 2'd0 && is_cont)
            begin
                partial = {state.partial_value[u8d_pkg::CP_W-7:0], b[5:0]};
                pending = state.bytes_pending - 2'd1;
                done    = (state.bytes_pending == 2'd1);
            end
            else if (state.bytes_pending == 2'd0 && is_cont)
            begin
                // stray continuation byte is dropped
            end
            else if (!b[7])
            begin
                partial = {{(u8d_pkg::CP_W-8){1'b0}}, b};
                pending = 2'd0;
                done    = 1'b1;
            end
            else if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT)
            begin
                partial = {{(u8d_pkg::CP_W-5){1'b0}}, b[4:0]};
                pending = 2'd1;
            end
            else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT)
            begin
                partial = {{(u8d_pkg::CP_W-4){1'b0}}, b[3:0]};
                pending = 2'd2;
            end
            else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT)
            begin
                partial = {{(u8d_pkg::CP_W-3){1'b0}}, b[2:0]};
                pending = 2'd3;
            end
            else
            begin
                // invalid lead byte
                partial = '0;
                pending = 2'd0;
            end
        end
    end

    // result fields
    always_comb
    begin
        result.code_point  = done ? partial : '0;
        result.char_index  = done ? cnt_ext[u8d_pkg::IDX_W-1:0] : '0;
        result.char_valid  = done;
        result.end_of_text = item.last_byte;
        has_result         = done || item.last_byte;
    end

    // next state, back to reset at the end of a text
    always_comb
    begin
        if (item.last_byte)
        begin
            state_next = '0;
        end
        else
        begin
            state_next.partial_value = done ? '0 : partial;
            state_next.bytes_pending = pending;
            state_next.chars_emitted = done ? state.chars_emitted + 1'b1
                                            : state.chars_emitted;
        end
    end

endmodule

FILE: design/utf8_stream_decoder.sv
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// input channel: in_valid / in_stall / in_data carry one text byte per
//   transaction; in_data.last_byte marks the final byte of a text
// output channel: out_valid / out_stall / out_data carry one result per
//   completed character, plus one with end_of_text set for the last byte
//   (char_valid tells whether that one also holds a character)
// path: a byte is captured in the input register, decoded combinationally
//   and written to the result register once the output is free, from
//   which its result is presented until it is taken
// throughput: one byte per clock unless out_stall holds a result; the sole
//   recurrence is the sequence state (partial value, pending count, char count)
// stray continuations, invalid leads and bytes past the character limit
//   make no result unless they are last; a byte that breaks a sequence
//   drops the partial character and is decoded again as a lead
// reset: both registers empty, decoder state cleared, a new text starts
//   at index zero; every last byte clears the decoder state the same way
// stall: while out_stall holds a result, the byte in the input register
//   waits and in_stall rises; no transaction is lost or repeated
module utf8_stream_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u8d_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output u8d_pkg::out_item_t out_data
);

    logic                in_valid_reg;
    u8d_pkg::in_item_t   in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    u8d_pkg::out_item_t  out_item_reg;
    u8d_pkg::dec_state_t state_reg;
    u8d_pkg::dec_state_t state_next;
    u8d_pkg::out_item_t  result;
    logic                has_result;
    logic                out_free;
    logic                advance;
    logic                in_take;

    u8d_decode u_decode (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result),
        .has_result (has_result)
    );

    // handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (advance)
            out_valid_next = has_result;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_data;
        if (advance && has_result)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: tb/sv/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    // byte classes of the UTF-8 encoding
    typedef enum {
        BK_ASCII,
        BK_CONT,
        BK_LEAD2,
        BK_LEAD3,
        BK_LEAD4,
        BK_BAD
    } byte_kind_t;

    function automatic byte_kind_t classify(logic [7:0] b);
        byte_kind_t kind;
        if (!b[7])
            kind = BK_ASCII;
        else if (b[7:6] == 2'b10)
            kind = BK_CONT;
        else if (b[7:5] == 3'b110)
            kind = BK_LEAD2;
        else if (b[7:4] == 4'b1110)
            kind = BK_LEAD3;
        else if (b[7:3] == 5'b11110)
            kind = BK_LEAD4;
        else
            kind = BK_BAD;
        return kind;
    endfunction

    // decodes accepted bytes on its own and checks each result against the oldest one
    class utf8_checker;
        logic [u8d_pkg::CP_W-1:0] partial;
        int unsigned              pending;
        int unsigned              chars;
        u8d_pkg::out_item_t       decoded_q[$];
        int                       errors;
        int                       bytes_taken;
        int                       chars_seen;
        int                       ends_seen;

        function new();
            clear();
            errors      = 0;
            bytes_taken = 0;
            chars_seen  = 0;
            ends_seen   = 0;
        endfunction

        function void clear();
            partial = '0;
            pending = 0;
            chars   = 0;
        endfunction

        function void note_byte(u8d_pkg::in_item_t it);
            byte_kind_t         kind;
            logic               done;
            u8d_pkg::out_item_t r;
            kind = classify(it.data_byte);
            done = 1'b0;
            r    = '0;
            bytes_taken++;
            // past the character limit no byte is decoded; a last byte still ends the text
            if (chars < u8d_pkg::MAX_CHARS)
            begin
                if (pending != 0 && kind == BK_CONT)
                begin
                    partial = {partial[u8d_pkg::CP_W-7:0], it.data_byte[5:0]};
                    pending--;
                    done = (pending == 0);
                end
                else if (kind != BK_CONT)
                begin
                    // new lead: a partial character is dropped and the byte starts over
                    case (kind)
                        BK_ASCII:
                        begin
                            partial = u8d_pkg::CP_W'(it.data_byte[6:0]);
                            pending = 0;
                            done    = 1'b1;
                        end
                        BK_LEAD2:
                        begin
                            partial = u8d_pkg::CP_W'(it.data_byte[4:0]);
                            pending = 1;
                        end
                        BK_LEAD3:
                        begin
                            partial = u8d_pkg::CP_W'(it.data_byte[3:0]);
                            pending = 2;
                        end
                        BK_LEAD4:
                        begin
                            partial = u8d_pkg::CP_W'(it.data_byte[2:0]);
                            pending = 3;
                        end
                        default:
                        begin
                            partial = '0;
                            pending = 0;
                        end
                    endcase
                end
                if (done)
                begin
                    r.code_point = partial;
                    r.char_index = u8d_pkg::IDX_W'(chars);
                    r.char_valid = 1'b1;
                    chars++;
                    partial = '0;
                end
            end
            if (done || it.last_byte)
            begin
                r.end_of_text = it.last_byte;
                decoded_q.push_back(r);
            end
            if (it.last_byte)
                clear();
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(u8d_pkg::out_item_t got);
            u8d_pkg::out_item_t want;
            if (decoded_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, actual cp %0h idx %0d valid %b end %b",
                         $time, got.code_point, got.char_index, got.char_valid,
                         got.end_of_text);
                return;
            end
            want = decoded_q.pop_front();
            compare("code_point", 32'(want.code_point), 32'(got.code_point));
            compare("char_index", 32'(want.char_index), 32'(got.char_index));
            compare("char_valid", 32'(want.char_valid), 32'(got.char_valid));
            compare("end_of_text", 32'(want.end_of_text), 32'(got.end_of_text));
            if (want.char_valid)
                chars_seen++;
            if (want.end_of_text)
                ends_seen++;
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    u8d_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    u8d_pkg::out_item_t out_data;

    utf8_checker sb;
    logic [7:0]  text_q[$];
    int          gap_max   = 10;
    int          stall_max = 10;

    utf8_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // one input transaction after a random gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int                gap;
        u8d_pkg::in_item_t it;
        gap          = $urandom_range(0, gap_max);
        it.data_byte = b;
        it.last_byte = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_byte(it);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // hold the input until every predicted result is out, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // complete lead-and-continuation sequence of len bytes with random payload
    function automatic void add_char(int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       text_q.push_back({1'b0, r[6:0]});
            2:       text_q.push_back({3'b110, r[4:0]});
            3:       text_q.push_back({4'b1110, r[3:0]});
            default: text_q.push_back({5'b11110, r[2:0]});
        endcase
        for (int k = 1; k < len; k++)
        begin
            r = 8'($urandom);
            text_q.push_back({2'b10, r[5:0]});
        end
    endfunction

    // bytes the decoder must drop or recover from
    function automatic void add_noise();
        logic [7:0] r;
        int         len;
        r = 8'($urandom);
        case ($urandom_range(0, 3))
            0: text_q.push_back(r);
            1: text_q.push_back({2'b10, r[5:0]});
            2: text_q.push_back({5'b11111, r[2:0]});
            default:
            begin
                len = $urandom_range(2, 4);
                add_char(len);
                repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
            end
        endcase
    endfunction

    // result side: random stalls, check every transaction
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int random_bytes;
        int n_chars;
        bit drained;
        sb           = new();
        random_bytes = 0;
        drained      = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1-/2-byte extremes, max 3-/4-byte, stray continuation, invalid leads, broken sequence
        text_q = {8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                  8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hFF, 8'hC3, 8'h41};
        send_text();
        // text ending inside a character
        text_q = {8'hE2, 8'h82};
        send_text();
        // text ending on a stray continuation
        text_q = {8'h80};
        send_text();
        wait_idle();

        // character limit: a long text at full rate, crossing the limit with chars of random length
        gap_max   = 0;
        stall_max = 2;
        for (int i = 0; i < u8d_pkg::MAX_CHARS - 2; i++)
            add_char(1);
        repeat (8) add_char($urandom_range(1, 4));
        add_char(1);
        send_text();
        wait_idle();

        // random texts: mostly complete characters, some noise and truncated endings
        while (random_bytes < 200)
        begin
            gap_max   = ($urandom_range(0, 4) == 0) ? 0 : 10;
            stall_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
            n_chars   = $urandom_range(1, 16);
            for (int i = 0; i < n_chars; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    add_noise();
                else
                    add_char($urandom_range(1, 4));
            end
            if ($urandom_range(0, 9) == 0)
                add_noise();
            random_bytes += text_q.size();
            send_text();
            if (!drained && random_bytes > 100)
            begin
                wait_idle();
                drained = 1'b1;
            end
        end

        stall_max = 0;
        wait_idle();
        repeat (10) @(posedge clk);

        $display("covered %0d bytes: %0d characters and %0d text ends checked",
                 sb.bytes_taken, sb.chars_seen, sb.ends_seen);
        $display("including all sequence lengths, dropped bytes and a text past %0d chars",
                 u8d_pkg::MAX_CHARS);
        if (sb.errors == 0 && sb.decoded_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
